[hw/rtl/mbe_pkg.sv]
`default_nettype none
package mbe_pkg;

   localparam int C_W = 32;
   localparam int CNT_W = 13;
   localparam int Z_W = 64;
   localparam int Z_FRAC = 40;

   // operand magnitudes stay below 2^50 wherever a product is formed
   localparam int MAG_W = 50;
   localparam int HALF_W = MAG_W / 2;
   localparam int PP_W = 2 * HALF_W;
   localparam int FULL_W = 2 * MAG_W;
   localparam int PROD_W = FULL_W - Z_FRAC;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   localparam logic [CNT_W-1:0] ITER_CAP_RESET = CNT_W'(100);

   localparam logic signed [Z_W-1:0] Z_ONE = 64'sd1 <<< Z_FRAC;
   localparam logic signed [Z_W-1:0] Z_QUARTER = Z_ONE >>> 2;
   localparam logic signed [Z_W-1:0] Z_TWO = Z_ONE <<< 1;
   localparam logic signed [Z_W-1:0] ESC_COMP = 64'sd633 <<< Z_FRAC;

   localparam logic [PROD_W:0] DISK_LIM = {{PROD_W{1'b0}}, 1'b1} << (Z_FRAC - 4);
   localparam logic [PROD_W:0] ESC_LIMIT =
      {{(PROD_W + 1 - 20){1'b0}}, 20'd400000} << Z_FRAC;

   typedef struct packed {
      logic signed [Z_W-1:0] c_real;
      logic signed [Z_W-1:0] c_imag;
      logic                  interior;
   } queue_item_type;

   function automatic logic [MAG_W-1:0] mag_trunc(input logic signed [Z_W-1:0] v);
      logic [Z_W-1:0] m;
      m = v[Z_W-1] ? (~v + Z_W'(1)) : v;
      return m[MAG_W-1:0];
   endfunction

   function automatic logic in_range(input logic signed [Z_W-1:0] v,
                                     input logic signed [Z_W-1:0] lim);
      return (v < lim) && (v > -lim);
   endfunction

endpackage
`default_nettype wire

[hw/rtl/mbe_qmul.sv]
`default_nettype none
// two-stage magnitude product, result is (a*b) >> Z_FRAC
module mbe_qmul (
   input  wire                             clock,
   input  wire  [mbe_pkg::MAG_W-1:0]       a_mag,
   input  wire  [mbe_pkg::MAG_W-1:0]       b_mag,
   output logic [mbe_pkg::PROD_W-1:0]      p_mag
);

   localparam int HW = mbe_pkg::HALF_W;
   localparam int PW = mbe_pkg::PP_W;
   localparam int FW = mbe_pkg::FULL_W;

   logic [PW-1:0] pp00_ff, pp01_ff, pp10_ff, pp11_ff;
   logic [mbe_pkg::PROD_W-1:0] p_mag_ff;
   logic [FW-1:0] mid_w, full_w;

   always_ff @(posedge clock) begin
      pp00_ff <= PW'(a_mag[HW-1:0]) * PW'(b_mag[HW-1:0]);
      pp01_ff <= PW'(a_mag[HW-1:0]) * PW'(b_mag[2*HW-1:HW]);
      pp10_ff <= PW'(a_mag[2*HW-1:HW]) * PW'(b_mag[HW-1:0]);
      pp11_ff <= PW'(a_mag[2*HW-1:HW]) * PW'(b_mag[2*HW-1:HW]);
   end

   assign mid_w = {{(FW-PW){1'b0}}, pp01_ff} + {{(FW-PW){1'b0}}, pp10_ff};
   assign full_w = {{(FW-PW){1'b0}}, pp00_ff} + (mid_w << HW) + {pp11_ff, {(FW-PW){1'b0}}};

   always_ff @(posedge clock) begin
      p_mag_ff <= full_w[FW-1:mbe_pkg::Z_FRAC];
   end

   assign p_mag = p_mag_ff;

endmodule
`default_nettype wire

[hw/rtl/mbe_queue.sv]
`default_nettype none
module mbe_queue (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            push,
   input  mbe_pkg::queue_item_type        push_item,
   output logic                           full,
   input  wire                            pop,
   output mbe_pkg::queue_item_type        pop_item,
   output logic                           empty
);

   mbe_pkg::queue_item_type entry_ff [mbe_pkg::QUEUE_DEPTH];
   logic [mbe_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [mbe_pkg::QCNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == mbe_pkg::QCNT_W'(mbe_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + mbe_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - mbe_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> !empty)
      else $error("queue empty after transfer in");

endmodule
`default_nettype wire

[hw/rtl/mbe_front.sv]
`default_nettype none
// takes a point, widens it and runs the period-2 disk and cardioid tests
module mbe_front #(
   parameter int FRAC_BITS = 28
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            push,
   output logic                           full,
   input  wire  signed [mbe_pkg::C_W-1:0] c_real,
   input  wire  signed [mbe_pkg::C_W-1:0] c_imag,
   output logic                           q_push,
   output mbe_pkg::queue_item_type        q_item,
   input  wire                            q_full
);

   localparam int IN_SHIFT = mbe_pkg::Z_FRAC - FRAC_BITS;
   localparam int ZW = mbe_pkg::Z_W;
   localparam int CW = mbe_pkg::C_W;
   localparam int MW = mbe_pkg::MAG_W;
   localparam int PRW = mbe_pkg::PROD_W;

   typedef enum logic [14:0] {
      F_IDLE = 15'h0001,
      F_PREP = 15'h0002,
      F_MAG  = 15'h0004,
      F_SQ0  = 15'h0008,
      F_SQ1  = 15'h0010,
      F_SQ2  = 15'h0020,
      F_W0   = 15'h0040,
      F_W1   = 15'h0080,
      F_Q    = 15'h0100,
      F_QX   = 15'h0200,
      F_QM   = 15'h0400,
      F_MUL  = 15'h0800,
      F_MW   = 15'h1000,
      F_CMP  = 15'h2000,
      F_PUSH = 15'h4000
   } front_state_type;

   front_state_type state_ff, state_in;

   logic signed [ZW-1:0] x_ff, y_ff, dx_ff, xs_ff, qx_ff;
   logic signed [ZW-1:0] cr_wide_w, ci_wide_w;
   logic [MW-1:0] dx_mag_ff, y_mag_ff, xs_mag_ff, qx_mag_ff;
   logic [MW-1:0] op_a_w, op_b_w;
   logic [PRW-1:0] dx2_ff, y2_ff, xs2_ff, p_w;
   logic [PRW:0] q_ff;
   logic disk_ok_ff, card_ok_ff, disk_ff, qx_neg_ff, interior_ff, card_w;
   logic accept;

   assign cr_wide_w = $signed({{(ZW-CW){c_real[CW-1]}}, c_real}) <<< IN_SHIFT;
   assign ci_wide_w = $signed({{(ZW-CW){c_imag[CW-1]}}, c_imag}) <<< IN_SHIFT;

   assign full = (state_ff != F_IDLE);
   assign accept = push && !full;
   assign q_push = (state_ff == F_PUSH);
   assign q_item = '{c_real: x_ff, c_imag: y_ff, interior: interior_ff};

   always_comb begin
      case (state_ff)
         F_SQ0: begin
            op_a_w = dx_mag_ff;
            op_b_w = dx_mag_ff;
         end
         F_SQ1: begin
            op_a_w = y_mag_ff;
            op_b_w = y_mag_ff;
         end
         F_SQ2: begin
            op_a_w = xs_mag_ff;
            op_b_w = xs_mag_ff;
         end
         F_MUL: begin
            op_a_w = q_ff[MW-1:0];
            op_b_w = qx_mag_ff;
         end
         default: begin
            op_a_w = '0;
            op_b_w = '0;
         end
      endcase
   end

   mbe_qmul u_qmul (
      .clock (clock),
      .a_mag (op_a_w),
      .b_mag (op_b_w),
      .p_mag (p_w)
   );

   // a negative nonzero product always lies below y^2/4
   assign card_w = card_ok_ff && ((qx_neg_ff && (p_w != '0)) || (p_w < (y2_ff >> 2)));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: if (accept) state_in = F_PREP;
         F_PREP: state_in = F_MAG;
         F_MAG:  state_in = F_SQ0;
         F_SQ0:  state_in = F_SQ1;
         F_SQ1:  state_in = F_SQ2;
         F_SQ2:  state_in = F_W0;
         F_W0:   state_in = F_W1;
         F_W1:   state_in = F_Q;
         F_Q:    state_in = F_QX;
         F_QX:   state_in = F_QM;
         F_QM:   state_in = F_MUL;
         F_MUL:  state_in = F_MW;
         F_MW:   state_in = F_CMP;
         F_CMP:  state_in = F_PUSH;
         F_PUSH: if (!q_full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               x_ff <= cr_wide_w;
               y_ff <= ci_wide_w;
            end
         end
         F_PREP: begin
            dx_ff <= x_ff + mbe_pkg::Z_ONE;
            xs_ff <= x_ff - mbe_pkg::Z_QUARTER;
         end
         F_MAG: begin
            dx_mag_ff <= mbe_pkg::mag_trunc(dx_ff);
            y_mag_ff <= mbe_pkg::mag_trunc(y_ff);
            xs_mag_ff <= mbe_pkg::mag_trunc(xs_ff);
            disk_ok_ff <= mbe_pkg::in_range(dx_ff, mbe_pkg::Z_QUARTER)
                          && mbe_pkg::in_range(y_ff, mbe_pkg::Z_QUARTER);
            card_ok_ff <= mbe_pkg::in_range(xs_ff, mbe_pkg::Z_TWO)
                          && mbe_pkg::in_range(y_ff, mbe_pkg::Z_TWO);
         end
         F_SQ2: dx2_ff <= p_w;
         F_W0:  y2_ff <= p_w;
         F_W1:  xs2_ff <= p_w;
         F_Q: begin
            q_ff <= {1'b0, xs2_ff} + {1'b0, y2_ff};
            disk_ff <= disk_ok_ff && (({1'b0, dx2_ff} + {1'b0, y2_ff}) < mbe_pkg::DISK_LIM);
         end
         F_QX: qx_ff <= $signed({{(ZW-PRW-1){1'b0}}, q_ff}) + xs_ff;
         F_QM: begin
            qx_mag_ff <= mbe_pkg::mag_trunc(qx_ff);
            qx_neg_ff <= qx_ff[ZW-1];
         end
         F_CMP: interior_ff <= disk_ff || card_w;
         default: begin
         end
      endcase
   end

   a_widen: assert property (@(posedge clock) disable iff (reset)
      accept |=> (x_ff == $past(cr_wide_w)) && (y_ff == $past(ci_wide_w)))
      else $error("point not captured on transfer");

endmodule
`default_nettype wire

[hw/rtl/mbe_back.sv]
`default_nettype none
// iterates z = z^2 + c for one point and holds the result for transfer
module mbe_back (
   input  wire                              clock,
   input  wire                              reset,
   input  wire  [mbe_pkg::CNT_W-1:0]        iter_cap,
   input  wire                              q_empty,
   input  mbe_pkg::queue_item_type          q_item,
   output logic                             q_pop,
   output logic                             rsp_empty,
   input  wire                              rsp_pop,
   output logic [mbe_pkg::CNT_W-1:0]        rsp_count
);

   localparam int ZW = mbe_pkg::Z_W;
   localparam int MW = mbe_pkg::MAG_W;
   localparam int PRW = mbe_pkg::PROD_W;
   localparam int NW = mbe_pkg::CNT_W;

   typedef enum logic [5:0] {
      B_IDLE = 6'b000001,
      B_MAG  = 6'b000010,
      B_MUL  = 6'b000100,
      B_SUM  = 6'b001000,
      B_UPD  = 6'b010000,
      B_DONE = 6'b100000
   } back_state_type;

   back_state_type state_ff, state_in;

   logic signed [ZW-1:0] cr_ff, ci_ff, zr_ff, zi_ff;
   logic [MW-1:0] zr_mag_ff, zi_mag_ff;
   logic comp_ff, cross_neg_ff;
   logic [NW-1:0] i_ff, res_ff, count_w;
   logic [PRW-1:0] sr_w, si_w, cross_w;
   logic esc_w, slot_free;
   logic rsp_valid_ff, rsp_valid_in;
   logic [NW-1:0] rsp_count_ff;

   mbe_qmul u_sq_re (.clock(clock), .a_mag(zr_mag_ff), .b_mag(zr_mag_ff), .p_mag(sr_w));
   mbe_qmul u_sq_im (.clock(clock), .a_mag(zi_mag_ff), .b_mag(zi_mag_ff), .p_mag(si_w));
   mbe_qmul u_cross (.clock(clock), .a_mag(zr_mag_ff), .b_mag(zi_mag_ff), .p_mag(cross_w));

   assign esc_w = (({1'b0, sr_w} + {1'b0, si_w}) >= mbe_pkg::ESC_LIMIT);
   assign count_w = (i_ff >= NW'(2)) ? i_ff - NW'(2) : '0;
   assign q_pop = (state_ff == B_IDLE) && !q_empty;
   assign slot_free = !rsp_valid_ff || rsp_pop;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_count = rsp_count_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (!q_empty) state_in = q_item.interior ? B_DONE : B_MAG;
         end
         B_MAG:  state_in = (i_ff == iter_cap) ? B_DONE : B_MUL;
         B_MUL:  state_in = comp_ff ? B_DONE : B_SUM;
         B_SUM:  state_in = B_UPD;
         B_UPD:  state_in = esc_w ? B_DONE : B_MAG;
         B_DONE: if (slot_free) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if ((state_ff == B_DONE) && slot_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            cr_ff <= q_item.c_real;
            ci_ff <= q_item.c_imag;
            zr_ff <= '0;
            zi_ff <= '0;
            i_ff <= '0;
            res_ff <= iter_cap;
         end
         B_MAG: begin
            zr_mag_ff <= mbe_pkg::mag_trunc(zr_ff);
            zi_mag_ff <= mbe_pkg::mag_trunc(zi_ff);
            comp_ff <= !mbe_pkg::in_range(zr_ff, mbe_pkg::ESC_COMP)
                       || !mbe_pkg::in_range(zi_ff, mbe_pkg::ESC_COMP);
            cross_neg_ff <= zr_ff[ZW-1] ^ zi_ff[ZW-1];
            res_ff <= iter_cap;
         end
         B_MUL: res_ff <= count_w;
         B_UPD: begin
            res_ff <= count_w;
            if (!esc_w) begin
               zr_ff <= $signed({{(ZW-PRW){1'b0}}, sr_w})
                        - $signed({{(ZW-PRW){1'b0}}, si_w}) + cr_ff;
               zi_ff <= cross_neg_ff
                        ? ci_ff - $signed({{(ZW-PRW-1){1'b0}}, cross_w, 1'b0})
                        : ci_ff + $signed({{(ZW-PRW-1){1'b0}}, cross_w, 1'b0});
               i_ff <= i_ff + NW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if ((state_ff == B_DONE) && slot_free) begin
         rsp_count_ff <= res_ff;
      end
   end

   a_step_count: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == B_UPD) && !esc_w) |=> (i_ff == $past(i_ff) + NW'(1)))
      else $error("iteration count did not advance");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_MUL) |-> (i_ff < iter_cap))
      else $error("iteration past limit");

   a_done_transfer: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == B_DONE) && slot_free) |=> (!rsp_empty && (rsp_count == $past(res_ff))))
      else $error("result lost on transfer out");

endmodule
`default_nettype wire

[hw/rtl/mandelbrot_escape_time.sv]
// Mandelbrot escape-time engine. A point c (signed, FRAC_BITS fraction bits) is
// transferred in through req_push/req_full, and its count comes out through
// rsp_empty/rsp_pop in arrival order. Points inside the period-2 disk or the
// main cardioid return max_iterations directly; otherwise z = z^2 + c runs in
// 64-bit fixed point with 40 fraction bits, and an escape after i steps
// returns i-2 (0 below two steps). The front classifies a point on one shared
// multiplier and takes the next point in the cycle after handing it on; a
// two-entry queue follows. Each back iteration steps through magnitude, partial
// products, product sum and update. An interior point skips the iterations, and
// a point with a component already large leaves before the product sum. The
// front's work on the next point overlaps the back's iterations.
// max_iterations is written through csr_wr_en/csr_wr_data; the user must
// write it only while no point is in flight, which the block does not
// enforce.
`default_nettype none
module mandelbrot_escape_time #(
   parameter int FRAC_BITS = 28
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_push,
   output logic                              req_full,
   input  wire  signed [mbe_pkg::C_W-1:0]    req_c_real,
   input  wire  signed [mbe_pkg::C_W-1:0]    req_c_imag,
   output logic                              rsp_empty,
   input  wire                               rsp_pop,
   output logic [mbe_pkg::CNT_W-1:0]         rsp_escape_count,
   input  wire                               csr_wr_en,
   input  wire  [mbe_pkg::CNT_W-1:0]         csr_wr_data
);

   logic [mbe_pkg::CNT_W-1:0] iter_cap_ff, iter_cap_in;
   mbe_pkg::queue_item_type push_item, pop_item;
   logic q_push, q_full, q_pop, q_empty;

   assign iter_cap_in = csr_wr_en ? csr_wr_data : iter_cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_cap_ff <= mbe_pkg::ITER_CAP_RESET;
      end else begin
         iter_cap_ff <= iter_cap_in;
      end
   end

   mbe_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock  (clock),
      .reset  (reset),
      .push   (req_push),
      .full   (req_full),
      .c_real (req_c_real),
      .c_imag (req_c_imag),
      .q_push (q_push),
      .q_item (push_item),
      .q_full (q_full)
   );

   mbe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .empty     (q_empty)
   );

   mbe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .iter_cap  (iter_cap_ff),
      .q_empty   (q_empty),
      .q_item    (pop_item),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_count (rsp_escape_count)
   );

endmodule
`default_nettype wire

[tb/mandelbrot_escape_time_checker.sv]
`timescale 1ns / 100ps
module mandelbrot_escape_time_checker #(
   parameter int FRAC_BITS = 28
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_push,
   input  wire                            req_full,
   input  wire signed [mbe_pkg::C_W-1:0]  req_c_real,
   input  wire signed [mbe_pkg::C_W-1:0]  req_c_imag,
   input  wire                            rsp_empty,
   input  wire                            rsp_pop,
   input  wire [mbe_pkg::CNT_W-1:0]       rsp_escape_count,
   input  wire                            csr_wr_en,
   input  wire [mbe_pkg::CNT_W-1:0]       csr_wr_data,
   output int                             fail_count,
   output int                             pending
);

   localparam int ZF = 40;
   localparam int WIDEN = ZF - FRAC_BITS;
   localparam logic signed [63:0] Q_ONE = 64'sd1 <<< ZF;
   localparam logic [63:0] Q_QUARTER = 64'd1 << (ZF - 2);
   localparam logic [63:0] Q_TWO = 64'd2 << ZF;
   localparam logic signed [63:0] DISK_RADIUS_SQ = 64'sd1 <<< (ZF - 4);
   localparam logic signed [63:0] CUSP_OFFSET = 64'sd1 <<< (ZF - 2);
   localparam logic [63:0] BAIL_COMPONENT = 64'd633 << ZF;
   localparam logic signed [63:0] BAIL_RADIUS_SQ = 64'sd400000 <<< ZF;
   localparam logic [mbe_pkg::CNT_W-1:0] LIMIT_AT_RESET = mbe_pkg::CNT_W'(100);

   typedef struct packed {
      logic [mbe_pkg::C_W-1:0]   c_real;
      logic [mbe_pkg::C_W-1:0]   c_imag;
      logic [mbe_pkg::CNT_W-1:0] count;
   } point_count_type;

   point_count_type           counts_due[$];
   point_count_type           head;
   point_count_type           fresh;
   logic [mbe_pkg::CNT_W-1:0] iter_limit;

   function automatic logic [63:0] abs_q(input logic signed [63:0] a);
      return a[63] ? -a : a;
   endfunction

   // exact product of magnitudes, truncated to ZF fraction bits, sign applied after
   function automatic logic signed [63:0] mul_q(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
      logic [127:0] p;
      logic [63:0]  m;
      p = {64'd0, abs_q(a)} * {64'd0, abs_q(b)};
      m = p[ZF+63:ZF];
      return (a[63] != b[63]) ? -m : m;
   endfunction

   function automatic logic in_disk(input logic signed [63:0] x,
                                    input logic signed [63:0] y);
      logic signed [63:0] dx;
      dx = x + Q_ONE;
      if (abs_q(dx) >= Q_QUARTER || abs_q(y) >= Q_QUARTER)
         return 1'b0;
      return (mul_q(dx, dx) + mul_q(y, y)) < DISK_RADIUS_SQ;
   endfunction

   function automatic logic in_main_body(input logic signed [63:0] x,
                                         input logic signed [63:0] y);
      logic signed [63:0] xs;
      logic signed [63:0] y2;
      logic signed [63:0] q;
      xs = x - CUSP_OFFSET;
      if (abs_q(xs) >= Q_TWO || abs_q(y) >= Q_TWO)
         return 1'b0;
      y2 = mul_q(y, y);
      q = mul_q(xs, xs) + y2;
      return mul_q(q, q + xs) < (y2 >>> 2);
   endfunction

   function automatic logic [mbe_pkg::CNT_W-1:0] escape_count(
      input logic signed [mbe_pkg::C_W-1:0] re,
      input logic signed [mbe_pkg::C_W-1:0] im,
      input logic [mbe_pkg::CNT_W-1:0]      lim
   );
      logic signed [63:0] cr;
      logic signed [63:0] ci;
      logic signed [63:0] zr;
      logic signed [63:0] zi;
      logic signed [63:0] sr;
      logic signed [63:0] si;
      logic signed [63:0] zr_zi;
      int                 steps;
      logic               gone;
      cr = re;
      ci = im;
      cr = cr <<< WIDEN;
      ci = ci <<< WIDEN;
      if (in_disk(cr, ci) || in_main_body(cr, ci))
         return lim;
      zr = '0;
      zi = '0;
      steps = 0;
      gone = 1'b0;
      while (steps < lim && !gone) begin
         if (abs_q(zr) >= BAIL_COMPONENT || abs_q(zi) >= BAIL_COMPONENT) begin
            gone = 1'b1;
         end else begin
            sr = mul_q(zr, zr);
            si = mul_q(zi, zi);
            if (sr + si >= BAIL_RADIUS_SQ) begin
               gone = 1'b1;
            end else begin
               zr_zi = mul_q(zr, zi);
               zr = sr - si + cr;
               zi = (zr_zi <<< 1) + ci;
               steps++;
            end
         end
      end
      if (steps == lim)
         return lim;
      if (steps >= 2)
         return mbe_pkg::CNT_W'(steps - 2);
      return '0;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         iter_limit = LIMIT_AT_RESET;
         counts_due.delete();
      end else begin
         if (csr_wr_en)
            iter_limit = csr_wr_data;
         if (req_push && !req_full) begin
            fresh.c_real = req_c_real;
            fresh.c_imag = req_c_imag;
            fresh.count = escape_count(req_c_real, req_c_imag, iter_limit);
            counts_due.push_back(fresh);
         end
         if (rsp_pop && !rsp_empty) begin
            if (counts_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected transfer: count %0d", rsp_escape_count);
            end else begin
               head = counts_due.pop_front();
               if (rsp_escape_count !== head.count) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("c = %h + i*%h: expected count %0d, got %0d",
                              head.c_real, head.c_imag, head.count, rsp_escape_count);
               end
            end
         end
      end
      pending = counts_due.size();
   end

endmodule

[tb/mandelbrot_escape_time_tb.sv]
`timescale 1ns / 100ps
module mandelbrot_escape_time_tb;

   localparam int MAX_GAP = 12;
   localparam int HOLD_AT = 200;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 20;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_push = 1'b0;
   logic                            req_full;
   logic signed [mbe_pkg::C_W-1:0]  req_c_real = '0;
   logic signed [mbe_pkg::C_W-1:0]  req_c_imag = '0;
   logic                            rsp_empty;
   logic                            rsp_pop = 1'b0;
   logic [mbe_pkg::CNT_W-1:0]       rsp_escape_count;
   logic                            csr_wr_en = 1'b0;
   logic [mbe_pkg::CNT_W-1:0]       csr_wr_data = '0;
   int                              fail_count;
   int                              pending;

   always #5 clock = ~clock;

   mandelbrot_escape_time u_top (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_c_real       (req_c_real),
      .req_c_imag       (req_c_imag),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_escape_count (rsp_escape_count),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   mandelbrot_escape_time_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_c_real       (req_c_real),
      .req_c_imag       (req_c_imag),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_escape_count (rsp_escape_count),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   // Q3.28 from a real value
   function automatic logic signed [31:0] fx(input real v);
      return $rtoi(v * 268435456.0);
   endfunction

   task automatic pick_point(output logic signed [31:0] re, output logic signed [31:0] im);
      logic [31:0] corners [5];
      corners = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001};
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: begin
            // window around the set
            re = fx(-2.1) + int'($urandom_range(0, fx(2.7)));
            im = fx(-1.3) + int'($urandom_range(0, fx(2.6)));
         end
         6, 7: begin
            re = $urandom;
            im = $urandom;
         end
         8: begin
            // near the bulb joints and the cusp
            case ($urandom_range(0, 3))
               0: begin re = fx(-0.75); im = '0; end
               1: begin re = fx(-1.25); im = '0; end
               2: begin re = fx(0.25); im = '0; end
               default: begin re = fx(-0.125); im = fx(0.649); end
            endcase
            re = re + int'($urandom_range(0, 131072)) - 65536;
            im = im + int'($urandom_range(0, 131072)) - 65536;
         end
         default: begin
            re = corners[$urandom_range(0, 4)];
            im = corners[$urandom_range(0, 4)];
         end
      endcase
   endtask

   task automatic offer_point(input logic signed [31:0] re, input logic signed [31:0] im,
                              input logic eager);
      int gap;
      gap = eager ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_c_real <= re;
      req_c_imag <= im;
      @(posedge clock);
      while (req_full) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_phase(input int n_points);
      logic signed [31:0] re;
      logic signed [31:0] im;
      logic               eager;
      eager = 1'b0;
      for (int k = 0; k < n_points; k++) begin
         if (k % 32 == 0)
            eager = ($urandom_range(0, 3) == 0);
         pick_point(re, im);
         offer_point(re, im, eager);
      end
   endtask

   task automatic settle();
      req_push <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_limit(input logic [mbe_pkg::CNT_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : pop_side
      int   gap;
      int   n_taken;
      logic steady;
      n_taken = 0;
      steady = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (n_taken % 40 == 0)
            steady = ($urandom_range(0, 2) == 0);
         gap = steady ? 0 : $urandom_range(0, MAX_GAP);
         // long hold so the input side backs up
         if (n_taken == HOLD_AT)
            gap = HOLD_CYCLES;
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         n_taken++;
         @(negedge clock);
      end
   end

   initial begin
      #(30_000_000);
      $display("FAIL");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset limit: edges of the disk and cardioid tests, escaping and extreme points
      offer_point(fx(0.0), fx(0.0), 1'b0);
      offer_point(fx(-1.0), fx(0.0), 1'b0);
      offer_point(fx(-1.25) + 1, fx(0.0), 1'b0);
      offer_point(fx(-1.25), fx(0.0), 1'b0);
      offer_point(fx(-1.0), fx(0.25), 1'b0);
      offer_point(fx(-1.0), fx(-0.25) + 1, 1'b0);
      offer_point(fx(0.25), fx(0.0), 1'b0);
      offer_point(fx(-0.75), fx(0.0), 1'b0);
      offer_point(fx(-1.75), fx(0.0), 1'b0);
      offer_point(fx(2.25), fx(0.0), 1'b0);
      offer_point(fx(0.0), fx(2.0), 1'b0);
      offer_point(fx(0.0), fx(-2.0), 1'b0);
      offer_point(fx(-2.0), fx(0.0), 1'b0);
      offer_point(fx(2.0), fx(0.0), 1'b0);
      offer_point(fx(1.0), fx(0.0), 1'b0);
      offer_point(fx(0.0), fx(1.0), 1'b0);
      offer_point(fx(0.3), fx(0.0), 1'b0);
      offer_point(fx(-0.1), fx(0.65), 1'b0);
      offer_point(fx(0.5), fx(0.5), 1'b0);
      offer_point(fx(-1.3), fx(0.0), 1'b0);
      offer_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
      offer_point(32'sh8000_0000, 32'sh8000_0000, 1'b0);
      offer_point(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
      offer_point(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
      settle();

      set_limit(13'd1);
      run_phase(60);
      settle();

      set_limit(13'd24);
      run_phase(300);
      settle();

      set_limit(13'd4096);
      offer_point(fx(-2.0), fx(0.0), 1'b0);
      offer_point(fx(-1.3), fx(0.0), 1'b0);
      run_phase(4);
      settle();

      set_limit(13'd0);
      run_phase(20);
      settle();

      set_limit(13'd100);
      run_phase(560);
      settle();

      set_limit(13'd2);
      run_phase(60);
      settle();

      set_limit(13'd4000);
      run_phase(6);
      settle();

      if (fail_count == 0 && pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
